[sv/rcsto_pkg.sv]
// ============================================================================
// rcsto_pkg - shared types and constants for the RC stick to targets block
// Field widths, pulse-width thresholds, fixed-point constants, codes and the
// sequencer state type, plus a saturating 32-bit conversion.
// ============================================================================
package rcsto_pkg;

    // Field widths
    localparam int unsigned CH_W        = 11;
    localparam int unsigned YAW_W       = 25;
    localparam int unsigned AMP_W       = 18;
    localparam int unsigned FREQ_W      = 21;
    localparam int unsigned RATE_W      = 17;
    localparam int unsigned AMP_OUT_W   = 20;
    localparam int unsigned BIAS_W      = 32;
    localparam int unsigned FREQ_OUT_W  = 23;
    localparam int unsigned ACT_W       = 2;
    localparam int unsigned REP_W       = 2;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 21;
    localparam int unsigned IN_TDATA_W  = 104;
    localparam int unsigned OUT_TDATA_W = 120;
    localparam int unsigned OUT_TUSER_W = 2;

    // Shared multiplier
    localparam int unsigned MUL_A_W  = 33;
    localparam int unsigned MUL_B_W  = 32;
    localparam int unsigned PROD_W   = 64;
    localparam int unsigned OFF_W    = 13;
    localparam int unsigned REC_IN_W = 30;
    localparam int unsigned WB_W     = 28;

    // Pulse-width thresholds (us)
    localparam logic [CH_W-1:0] PW_SOURCE = 11'd1500;
    localparam logic [CH_W-1:0] PW_ZERO   = 11'd1750;
    localparam logic [CH_W-1:0] PW_LOW    = 11'd1250;
    localparam logic signed [OFF_W-1:0] PW_CENTER_S = 13'sd1500;
    localparam logic signed [OFF_W-1:0] PW_FULL_S   = 13'sd2000;

    // x / 125 == (x * RECIP_125) >> RECIP_SHIFT, exact for x below 2^30
    localparam logic [30:0] RECIP_125   = 31'd1099511628;
    localparam int unsigned RECIP_SHIFT = 37;

    // pi / 180 in Q30
    localparam logic [24:0] DEG2RAD_Q30 = 25'd18740330;
    localparam logic [PROD_W-1:0] Q30_ROUND = 64'h0000_0000_3FFF_FFFF;

    // Reset values of the configuration registers
    localparam logic [AMP_W-1:0]  AMP0_RST  = 18'd11438;
    localparam logic [AMP_W-1:0]  AMP1_RST  = 18'd22877;
    localparam logic [AMP_W-1:0]  AMP2_RST  = 18'd34315;
    localparam logic [AMP_W-1:0]  BIAS_RST  = 18'd34315;
    localparam logic [FREQ_W-1:0] FREQ_RST  = 21'd327680;
    localparam logic [RATE_W-1:0] RATE_RST  = 17'd1311;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_AMP0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMP1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMP2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIAS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FREQ = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATE = 3'd5;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ZERO    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TARGETS = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CAPTURE = 2'd3;

    // Replay request codes
    localparam logic [REP_W-1:0] REPLAY_NONE  = 2'd0;
    localparam logic [REP_W-1:0] REPLAY_LEFT  = 2'd1;
    localparam logic [REP_W-1:0] REPLAY_RIGHT = 2'd2;

    // Operations run through the shared multiplier
    localparam logic [2:0] OP_STEER = 3'd0;
    localparam logic [2:0] OP_AMP0  = 3'd1;
    localparam logic [2:0] OP_AMP1  = 3'd2;
    localparam logic [2:0] OP_AMP2  = 3'd3;
    localparam logic [2:0] OP_FREQ  = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_REC  = 7'b0000100,
        S_HMUL = 7'b0001000,
        S_HWB  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    function automatic logic signed [BIAS_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

[sv/rc_stick_to_oscillator_targets.sv]
// ============================================================================
// rc_stick_to_oscillator_targets - radio frame to oscillator targets
// Decodes one RC frame into control source, action, joint amplitudes, bias,
// frequency and a gait replay request; tracks heading hold state.
// ============================================================================
//
//  channel   | direction | contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one RC frame with measured yaw and replay busy
//  m_axis    | out       | one result per frame, action code on tuser
//  cfg       | in        | register write: amplitudes, bias, frequency, rate
//
//  A frame that needs no arithmetic (replay busy, zero mode, heading capture)
//  goes from idle to the output state and is loaded into the output register
//  once that register is free. Each of the five products and its division
//  by 500 or 1000 takes two passes through the one shared multiplier, and
//  heading hold adds one more product for the degree to radian conversion.
//  Reset is synchronous, active low. The input is ready only while idle; a
//  finished result waits in the output register and the next frame may enter.
//
module rc_stick_to_oscillator_targets (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // steer[10:0] speed[21:11] swing[32:22] mode[43:33] source[54:44]
    // left_replay[65:55] right_replay[76:66] measured_yaw[101:77]
    // replay_busy[102]
    input  logic [rcsto_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // control_source[0] amp_out_joint0[20:1] amp_out_joint1[40:21]
    // amp_out_joint2[60:41] bias_out[92:61] frequency_out[115:93]
    // replay_request[117:116]
    output logic [rcsto_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // action[1:0]
    output logic [rcsto_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [rcsto_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rcsto_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    rcsto_pkg::t_state r_state, n_state;

    // Configuration
    logic [rcsto_pkg::AMP_W-1:0]  r_amp0, r_amp1, r_amp2, r_bias_scale;
    logic [rcsto_pkg::FREQ_W-1:0] r_base_freq;
    logic [rcsto_pkg::RATE_W-1:0] r_rate;

    // Heading hold state
    logic                                r_engaged;
    logic signed [rcsto_pkg::BIAS_W-1:0] r_desired;

    // Sequencer
    logic [2:0] r_op, r_wb_op;
    logic       r_wb_en;
    logic       r_heading;
    logic       r_neg;
    logic signed [rcsto_pkg::PROD_W-1:0] r_prod;

    // Captured frame
    logic [rcsto_pkg::CH_W-1:0]         r_steer, r_speed, r_swing;
    logic signed [rcsto_pkg::YAW_W-1:0] r_yaw;

    // Result
    logic                                  r_src;
    logic [rcsto_pkg::ACT_W-1:0]           r_act;
    logic [rcsto_pkg::REP_W-1:0]           r_replay;
    logic [rcsto_pkg::AMP_OUT_W-1:0]       r_a0, r_a1, r_a2;
    logic signed [rcsto_pkg::BIAS_W-1:0]   r_bias;
    logic [rcsto_pkg::FREQ_OUT_W-1:0]      r_freq;

    // Output register
    logic                                 r_o_valid;
    logic [rcsto_pkg::OUT_TDATA_W-1:0]    r_o_tdata;
    logic [rcsto_pkg::OUT_TUSER_W-1:0]    r_o_tuser;

    // Frame fields
    logic [rcsto_pkg::CH_W-1:0]         w_steer, w_speed, w_swing, w_mode, w_source;
    logic [rcsto_pkg::CH_W-1:0]         w_left, w_right;
    logic signed [rcsto_pkg::YAW_W-1:0] w_yaw;
    logic                               w_busy;

    logic w_accept, w_zero, w_manual, w_arith, w_out_free;

    logic signed [rcsto_pkg::OFF_W-1:0]   w_steer_off, w_swing_off, w_speed_off;
    logic signed [rcsto_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [rcsto_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [rcsto_pkg::PROD_W:0]    w_prod;
    logic [rcsto_pkg::PROD_W-1:0]         w_mag, w_mag_sh;
    logic [rcsto_pkg::REC_IN_W-1:0]       w_rec_in;
    logic [rcsto_pkg::PROD_W-rcsto_pkg::RECIP_SHIFT-1:0] w_quot;
    logic signed [rcsto_pkg::WB_W-1:0]    w_wb_val;
    logic signed [rcsto_pkg::MUL_A_W-1:0] w_yaw_err;
    logic signed [33:0]                   w_yaw_sum;
    logic [rcsto_pkg::PROD_W-1:0]         w_hadj;

    assign w_steer  = i_s_axis_tdata[10:0];
    assign w_speed  = i_s_axis_tdata[21:11];
    assign w_swing  = i_s_axis_tdata[32:22];
    assign w_mode   = i_s_axis_tdata[43:33];
    assign w_source = i_s_axis_tdata[54:44];
    assign w_left   = i_s_axis_tdata[65:55];
    assign w_right  = i_s_axis_tdata[76:66];
    assign w_yaw    = $signed(i_s_axis_tdata[101:77]);
    assign w_busy   = i_s_axis_tdata[102];

    assign o_s_axis_tready = (r_state == rcsto_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && (r_state == rcsto_pkg::S_IDLE);
    assign w_out_free      = !r_o_valid || i_m_axis_tready;

    assign w_zero   = (w_mode > rcsto_pkg::PW_ZERO);
    assign w_manual = !w_zero && (w_mode > rcsto_pkg::PW_LOW);
    assign w_arith  = !w_busy && (w_manual || (!w_zero && r_engaged));

    assign w_steer_off = $signed({2'b00, r_steer}) - rcsto_pkg::PW_CENTER_S;
    assign w_swing_off = rcsto_pkg::PW_FULL_S - $signed({2'b00, r_swing});
    assign w_speed_off = rcsto_pkg::PW_FULL_S - $signed({2'b00, r_speed});
    assign w_yaw_err   = 33'(r_desired) - 33'(r_yaw);

    // Magnitude of the product, prescaled so that only a division by 125 remains
    assign w_mag    = r_prod[rcsto_pkg::PROD_W-1] ? (-r_prod) : r_prod;
    assign w_mag_sh = (r_op == rcsto_pkg::OP_STEER) ? (w_mag >> 2) : (w_mag >> 3);
    assign w_rec_in = w_mag_sh[rcsto_pkg::REC_IN_W-1:0];

    // Shared multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            rcsto_pkg::S_MUL: begin
                unique case (r_op)
                    rcsto_pkg::OP_STEER: begin
                        w_mul_a = r_heading ? $signed({16'd0, r_rate})
                                            : $signed({15'd0, r_bias_scale});
                        w_mul_b = 32'(w_steer_off);
                    end
                    rcsto_pkg::OP_AMP0: begin
                        w_mul_a = $signed({15'd0, r_amp0});
                        w_mul_b = 32'(w_swing_off);
                    end
                    rcsto_pkg::OP_AMP1: begin
                        w_mul_a = $signed({15'd0, r_amp1});
                        w_mul_b = 32'(w_swing_off);
                    end
                    rcsto_pkg::OP_AMP2: begin
                        w_mul_a = $signed({15'd0, r_amp2});
                        w_mul_b = 32'(w_swing_off);
                    end
                    rcsto_pkg::OP_FREQ: begin
                        w_mul_a = $signed({12'd0, r_base_freq});
                        w_mul_b = 32'(w_speed_off);
                    end
                    default: begin
                        w_mul_a = '0;
                        w_mul_b = '0;
                    end
                endcase
            end
            rcsto_pkg::S_REC: begin
                w_mul_a = $signed({3'd0, w_rec_in});
                w_mul_b = $signed({1'b0, rcsto_pkg::RECIP_125});
            end
            rcsto_pkg::S_HMUL: begin
                w_mul_a = w_yaw_err;
                w_mul_b = $signed({7'd0, rcsto_pkg::DEG2RAD_Q30});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Quotient from the reciprocal product, sign restored (truncates toward zero)
    assign w_quot   = r_prod[rcsto_pkg::PROD_W-1:rcsto_pkg::RECIP_SHIFT];
    assign w_wb_val = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
    assign w_yaw_sum = 34'(r_desired) + 34'(w_wb_val);

    // Arithmetic shift by 30 that truncates toward zero
    assign w_hadj = r_prod + (r_prod[rcsto_pkg::PROD_W-1] ? rcsto_pkg::Q30_ROUND
                                                          : {rcsto_pkg::PROD_W{1'b0}});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcsto_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_arith ? rcsto_pkg::S_MUL : rcsto_pkg::S_OUT;
                end
            end
            rcsto_pkg::S_MUL:  n_state = rcsto_pkg::S_REC;
            rcsto_pkg::S_REC: begin
                if (r_op == rcsto_pkg::OP_FREQ) begin
                    n_state = r_heading ? rcsto_pkg::S_HMUL : rcsto_pkg::S_FIN;
                end else begin
                    n_state = rcsto_pkg::S_MUL;
                end
            end
            rcsto_pkg::S_HMUL: n_state = rcsto_pkg::S_HWB;
            rcsto_pkg::S_HWB:  n_state = rcsto_pkg::S_OUT;
            rcsto_pkg::S_FIN:  n_state = rcsto_pkg::S_OUT;
            rcsto_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = rcsto_pkg::S_IDLE;
                end
            end
            default: n_state = rcsto_pkg::S_IDLE;
        endcase
    end

    // Control state, configuration and heading hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rcsto_pkg::S_IDLE;
            r_op         <= rcsto_pkg::OP_STEER;
            r_wb_en      <= 1'b0;
            r_o_valid    <= 1'b0;
            r_engaged    <= 1'b0;
            r_desired    <= '0;
            r_amp0       <= rcsto_pkg::AMP0_RST;
            r_amp1       <= rcsto_pkg::AMP1_RST;
            r_amp2       <= rcsto_pkg::AMP2_RST;
            r_bias_scale <= rcsto_pkg::BIAS_RST;
            r_base_freq  <= rcsto_pkg::FREQ_RST;
            r_rate       <= rcsto_pkg::RATE_RST;
        end else begin
            r_state <= n_state;
            r_wb_en <= (r_state == rcsto_pkg::S_REC);

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    rcsto_pkg::CFG_AMP0: r_amp0       <= i_cfg_wdata[rcsto_pkg::AMP_W-1:0];
                    rcsto_pkg::CFG_AMP1: r_amp1       <= i_cfg_wdata[rcsto_pkg::AMP_W-1:0];
                    rcsto_pkg::CFG_AMP2: r_amp2       <= i_cfg_wdata[rcsto_pkg::AMP_W-1:0];
                    rcsto_pkg::CFG_BIAS: r_bias_scale <= i_cfg_wdata[rcsto_pkg::AMP_W-1:0];
                    rcsto_pkg::CFG_FREQ: r_base_freq  <= i_cfg_wdata[rcsto_pkg::FREQ_W-1:0];
                    rcsto_pkg::CFG_RATE: r_rate       <= i_cfg_wdata[rcsto_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_op <= rcsto_pkg::OP_STEER;
            end else if (r_state == rcsto_pkg::S_REC) begin
                r_op <= r_op + 3'd1;
            end

            // Leave, enter or keep heading hold
            if (w_accept && !w_busy) begin
                if (w_zero || w_manual) begin
                    r_engaged <= 1'b0;
                end else if (!r_engaged) begin
                    r_desired <= 32'(w_yaw);
                    r_engaged <= 1'b1;
                end
            end

            // Integrate the steering step into the desired yaw
            if (r_wb_en && r_heading && (r_wb_op == rcsto_pkg::OP_STEER)) begin
                r_desired <= rcsto_pkg::sat32(w_yaw_sum);
            end

            if (r_state == rcsto_pkg::S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_steer   <= w_steer;
            r_speed   <= w_speed;
            r_swing   <= w_swing;
            r_yaw     <= w_yaw;
            r_heading <= !w_zero && !w_manual && r_engaged;
            r_src     <= (w_source > rcsto_pkg::PW_SOURCE);
            r_a0      <= '0;
            r_a1      <= '0;
            r_a2      <= '0;
            r_bias    <= '0;
            r_freq    <= '0;
            priority if (w_busy) begin
                r_act <= rcsto_pkg::ACT_NONE;
            end else if (w_zero) begin
                r_act <= rcsto_pkg::ACT_ZERO;
            end else if (w_manual || r_engaged) begin
                r_act <= rcsto_pkg::ACT_TARGETS;
            end else begin
                r_act <= rcsto_pkg::ACT_CAPTURE;
            end
            priority if (w_busy) begin
                r_replay <= rcsto_pkg::REPLAY_NONE;
            end else if (w_left < rcsto_pkg::PW_LOW) begin
                r_replay <= rcsto_pkg::REPLAY_LEFT;
            end else if (w_right < rcsto_pkg::PW_LOW) begin
                r_replay <= rcsto_pkg::REPLAY_RIGHT;
            end else begin
                r_replay <= rcsto_pkg::REPLAY_NONE;
            end
        end

        if (r_state == rcsto_pkg::S_MUL || r_state == rcsto_pkg::S_REC ||
            r_state == rcsto_pkg::S_HMUL) begin
            r_prod <= w_prod[rcsto_pkg::PROD_W-1:0];
        end

        if (r_state == rcsto_pkg::S_REC) begin
            r_neg   <= r_prod[rcsto_pkg::PROD_W-1];
            r_wb_op <= r_op;
        end

        // Write back the quotient of the previous operation
        if (r_wb_en) begin
            unique case (r_wb_op)
                rcsto_pkg::OP_STEER: begin
                    if (!r_heading) begin
                        r_bias <= 32'(w_wb_val);
                    end
                end
                rcsto_pkg::OP_AMP0: r_a0   <= w_wb_val[rcsto_pkg::AMP_OUT_W-1:0];
                rcsto_pkg::OP_AMP1: r_a1   <= w_wb_val[rcsto_pkg::AMP_OUT_W-1:0];
                rcsto_pkg::OP_AMP2: r_a2   <= w_wb_val[rcsto_pkg::AMP_OUT_W-1:0];
                rcsto_pkg::OP_FREQ: r_freq <= w_wb_val[rcsto_pkg::FREQ_OUT_W-1:0];
                default: ;
            endcase
        end

        if (r_state == rcsto_pkg::S_HWB) begin
            r_bias <= rcsto_pkg::sat32($signed(w_hadj[rcsto_pkg::PROD_W-1:30]));
        end

        if (r_state == rcsto_pkg::S_OUT && w_out_free) begin
            r_o_tdata <= {2'b00, r_replay, r_freq, r_bias, r_a2, r_a1, r_a0, r_src};
            r_o_tuser <= r_act;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_tdata;
    assign o_m_axis_tuser  = r_o_tuser;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for rc_stick_to_oscillator_targets
// Sends radio frames over the input stream and checks every result, field by
// field, against a cycle-free model of the frame decoder or, for known rows,
// against the directed table. The model tracks heading hold and the register
// settings. The directed table covers the thresholds, the extremes and each
// mode. Random runs of well-formed frames, mixed with noise, follow under
// several register settings. Both stream sides idle and stall at random.
// ============================================================================
module tb;

    localparam int           CYCLE_LIMIT     = 400000;
    localparam int           LONG_HOLD       = 300;
    localparam longint       RAD_PER_DEG_Q30 = 64'sd18740330;
    localparam longint       Q30_ONE         = 64'sd1073741824;

    localparam logic [rcsto_pkg::CFG_ADDR_W-1:0] REG_IDX [6] =
        '{rcsto_pkg::CFG_AMP0, rcsto_pkg::CFG_AMP1, rcsto_pkg::CFG_AMP2,
          rcsto_pkg::CFG_BIAS, rcsto_pkg::CFG_FREQ, rcsto_pkg::CFG_RATE};
    localparam int REG_TOP [6] = '{131072, 131072, 131072, 131072, 1310720, 65536};
    localparam int REG_W   [6] = '{18, 18, 18, 18, 21, 17};

    typedef struct packed {
        logic [rcsto_pkg::CH_W-1:0]         steer;
        logic [rcsto_pkg::CH_W-1:0]         speed;
        logic [rcsto_pkg::CH_W-1:0]         swing;
        logic [rcsto_pkg::CH_W-1:0]         mode;
        logic [rcsto_pkg::CH_W-1:0]         source;
        logic [rcsto_pkg::CH_W-1:0]         left_rep;
        logic [rcsto_pkg::CH_W-1:0]         right_rep;
        logic signed [rcsto_pkg::YAW_W-1:0] yaw;
        logic                               busy;
    } t_rc_frame;

    typedef struct packed {
        logic                             src;
        logic [rcsto_pkg::ACT_W-1:0]      action;
        logic [rcsto_pkg::AMP_OUT_W-1:0]  amp0;
        logic [rcsto_pkg::AMP_OUT_W-1:0]  amp1;
        logic [rcsto_pkg::AMP_OUT_W-1:0]  amp2;
        logic [rcsto_pkg::BIAS_W-1:0]     bias;
        logic [rcsto_pkg::FREQ_OUT_W-1:0] freq;
        logic [rcsto_pkg::REP_W-1:0]      replay;
    } t_targets;

    typedef struct {
        t_rc_frame f;
        bit        known;
        t_targets  want;
    } t_stim_row;

    typedef enum int {KIND_ZERO, KIND_MANUAL, KIND_HEADING} t_frame_kind;
    typedef enum int {SWEEP_RANDOM, SWEEP_ZERO, SWEEP_TOP, SWEEP_ONES} t_cfg_sweep;

    logic                               i_clk;
    logic                               i_rst_n;
    logic [rcsto_pkg::IN_TDATA_W-1:0]   s_tdata;
    logic                               s_tvalid;
    logic                               o_s_axis_tready;
    logic [rcsto_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [rcsto_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser;
    logic                               o_m_axis_tvalid;
    logic                               m_tready;
    logic                               cfg_we;
    logic [rcsto_pkg::CFG_ADDR_W-1:0]   cfg_addr;
    logic [rcsto_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    // decoder model: register copy and heading state
    logic [rcsto_pkg::AMP_W-1:0]  cfg_amp [3];
    logic [rcsto_pkg::AMP_W-1:0]  cfg_bias_scale;
    logic [rcsto_pkg::FREQ_W-1:0] cfg_base_freq;
    logic [rcsto_pkg::RATE_W-1:0] cfg_heading_rate;
    bit                           hold_engaged;
    longint                       yaw_goal;

    t_targets pending_targets [$];
    int       mismatches;
    int       hold_requests;
    int       holds_served;
    bit       rx_jitter;
    int       cycle_count;

    rc_stick_to_oscillator_targets dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clip_i32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_targets predict_targets(input t_rc_frame f);
        t_targets r;
        longint   steer_off;
        longint   speed_span;
        longint   swing_span;
        longint   yaw;
        longint   bias;
        longint   freq;
        longint   amp [3];
        bit       targets_on;
        r          = '0;
        steer_off  = longint'(f.steer) - 1500;
        speed_span = 2000 - longint'(f.speed);
        swing_span = 2000 - longint'(f.swing);
        yaw        = longint'($signed(f.yaw));
        targets_on = 1'b0;
        bias       = 0;
        r.src      = (f.source > rcsto_pkg::PW_SOURCE);
        r.action   = rcsto_pkg::ACT_NONE;
        r.replay   = rcsto_pkg::REPLAY_NONE;
        if (!f.busy) begin
            if (f.mode > rcsto_pkg::PW_ZERO) begin
                r.action     = rcsto_pkg::ACT_ZERO;
                hold_engaged = 1'b0;
            end else if (f.mode > rcsto_pkg::PW_LOW) begin
                r.action     = rcsto_pkg::ACT_TARGETS;
                targets_on   = 1'b1;
                bias         = longint'(cfg_bias_scale) * steer_off / 500;
                hold_engaged = 1'b0;
            end else if (!hold_engaged) begin
                yaw_goal     = yaw;
                hold_engaged = 1'b1;
                r.action     = rcsto_pkg::ACT_CAPTURE;
            end else begin
                // advance the goal first, then steer on the heading error
                yaw_goal   = clip_i32(yaw_goal + longint'(cfg_heading_rate) * steer_off / 500);
                r.action   = rcsto_pkg::ACT_TARGETS;
                targets_on = 1'b1;
                bias       = clip_i32((yaw_goal - yaw) * RAD_PER_DEG_Q30 / Q30_ONE);
            end
            if (targets_on) begin
                for (int k = 0; k < 3; k++) begin
                    amp[k] = longint'(cfg_amp[k]) * swing_span / 1000;
                end
                freq   = longint'(cfg_base_freq) * speed_span / 1000;
                r.amp0 = amp[0][rcsto_pkg::AMP_OUT_W-1:0];
                r.amp1 = amp[1][rcsto_pkg::AMP_OUT_W-1:0];
                r.amp2 = amp[2][rcsto_pkg::AMP_OUT_W-1:0];
                r.bias = bias[rcsto_pkg::BIAS_W-1:0];
                r.freq = freq[rcsto_pkg::FREQ_OUT_W-1:0];
            end
            if (f.left_rep < rcsto_pkg::PW_LOW) begin
                r.replay = rcsto_pkg::REPLAY_LEFT;
            end else if (f.right_rep < rcsto_pkg::PW_LOW) begin
                r.replay = rcsto_pkg::REPLAY_RIGHT;
            end
        end
        return r;
    endfunction

    function automatic t_rc_frame mk_frame(input int steer, input int speed, input int swing,
                                           input int mode, input int source, input int left_rep,
                                           input int right_rep, input int yaw, input bit busy);
        t_rc_frame f;
        f.steer     = steer[rcsto_pkg::CH_W-1:0];
        f.speed     = speed[rcsto_pkg::CH_W-1:0];
        f.swing     = swing[rcsto_pkg::CH_W-1:0];
        f.mode      = mode[rcsto_pkg::CH_W-1:0];
        f.source    = source[rcsto_pkg::CH_W-1:0];
        f.left_rep  = left_rep[rcsto_pkg::CH_W-1:0];
        f.right_rep = right_rep[rcsto_pkg::CH_W-1:0];
        f.yaw       = yaw[rcsto_pkg::YAW_W-1:0];
        f.busy      = busy;
        return f;
    endfunction

    function automatic t_targets mk_targets(input bit src,
                                            input logic [rcsto_pkg::ACT_W-1:0] action,
                                            input int a0, input int a1, input int a2,
                                            input int bias, input int freq,
                                            input logic [rcsto_pkg::REP_W-1:0] replay);
        t_targets r;
        r.src    = src;
        r.action = action;
        r.amp0   = a0[rcsto_pkg::AMP_OUT_W-1:0];
        r.amp1   = a1[rcsto_pkg::AMP_OUT_W-1:0];
        r.amp2   = a2[rcsto_pkg::AMP_OUT_W-1:0];
        r.bias   = bias;
        r.freq   = freq[rcsto_pkg::FREQ_OUT_W-1:0];
        r.replay = replay;
        return r;
    endfunction

    function automatic logic [rcsto_pkg::IN_TDATA_W-1:0] pack_frame(input t_rc_frame f);
        logic [rcsto_pkg::IN_TDATA_W-1:0] d;
        d         = '0;
        d[10:0]   = f.steer;
        d[21:11]  = f.speed;
        d[32:22]  = f.swing;
        d[43:33]  = f.mode;
        d[54:44]  = f.source;
        d[65:55]  = f.left_rep;
        d[76:66]  = f.right_rep;
        d[101:77] = f.yaw;
        d[102]    = f.busy;
        return d;
    endfunction

    function automatic t_rc_frame gen_frame(input t_frame_kind kind, input bit noisy);
        t_rc_frame f;
        int        mode;
        int        yaw;
        case (kind)
            KIND_ZERO:   mode = $urandom_range(1751, 2047);
            KIND_MANUAL: mode = $urandom_range(1251, 1750);
            default:     mode = noisy ? $urandom_range(0, 1250) : $urandom_range(1000, 1250);
        endcase
        if (noisy) begin
            yaw = int'($urandom);
            f = mk_frame($urandom_range(0, 2047), $urandom_range(0, 2047),
                         $urandom_range(0, 2047), mode, $urandom_range(0, 2047),
                         $urandom_range(0, 2047), $urandom_range(0, 2047), yaw,
                         $urandom_range(0, 9) == 0);
        end else begin
            yaw = int'($urandom_range(0, 23592960)) - 11796480;
            f = mk_frame($urandom_range(1000, 2000), $urandom_range(1000, 2000),
                         $urandom_range(1000, 2000), mode, $urandom_range(1000, 2000),
                         $urandom_range(1000, 2000), $urandom_range(1000, 2000), yaw,
                         $urandom_range(0, 9) == 0);
        end
        return f;
    endfunction

    // offer one request, hold it until taken, then queue what it should give
    task automatic send_frame(input t_rc_frame f, input bit known, input t_targets want,
                              input int gap);
        t_targets model;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= pack_frame(f);
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        model = predict_targets(f);
        pending_targets.push_back(known ? want : model);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_targets.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg_sweep sweep);
        logic [rcsto_pkg::CFG_DATA_W-1:0] v;
        for (int i = 0; i < 6; i++) begin
            case (sweep)
                SWEEP_RANDOM: v = rcsto_pkg::CFG_DATA_W'($urandom_range(0, REG_TOP[i]));
                SWEEP_ZERO:   v = '0;
                SWEEP_TOP:    v = rcsto_pkg::CFG_DATA_W'(REG_TOP[i]);
                default:      v = rcsto_pkg::CFG_DATA_W'((1 << REG_W[i]) - 1);
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_IDX[i];
            cfg_wdata <= v;
            @(posedge i_clk);
            case (REG_IDX[i])
                rcsto_pkg::CFG_AMP0: cfg_amp[0]       = v[rcsto_pkg::AMP_W-1:0];
                rcsto_pkg::CFG_AMP1: cfg_amp[1]       = v[rcsto_pkg::AMP_W-1:0];
                rcsto_pkg::CFG_AMP2: cfg_amp[2]       = v[rcsto_pkg::AMP_W-1:0];
                rcsto_pkg::CFG_BIAS: cfg_bias_scale   = v[rcsto_pkg::AMP_W-1:0];
                rcsto_pkg::CFG_FREQ: cfg_base_freq    = v[rcsto_pkg::FREQ_W-1:0];
                default:             cfg_heading_rate = v[rcsto_pkg::RATE_W-1:0];
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // runs of one mode with random content, plus busy and noisy frames
    task automatic run_phase(input int n_items, input bit jitter);
        int          sent;
        int          run_len;
        int          pick;
        int          gap;
        bit          quiet;
        t_frame_kind kind;
        t_targets    none;
        sent = 0;
        none = '0;
        while (sent < n_items) begin
            pick    = $urandom_range(0, 19);
            kind    = (pick < 10) ? KIND_HEADING : (pick < 16) ? KIND_MANUAL : KIND_ZERO;
            run_len = $urandom_range(3, 16);
            quiet   = !jitter || ($urandom_range(0, 3) == 0);
            repeat (run_len) begin
                gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
                send_frame(gen_frame(kind, $urandom_range(0, 7) == 0), 1'b0, none, gap);
                sent++;
            end
        end
    endtask

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_targets got;
        t_targets want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got.src    = o_m_axis_tdata[0];
            got.amp0   = o_m_axis_tdata[20:1];
            got.amp1   = o_m_axis_tdata[40:21];
            got.amp2   = o_m_axis_tdata[60:41];
            got.bias   = o_m_axis_tdata[92:61];
            got.freq   = o_m_axis_tdata[115:93];
            got.replay = o_m_axis_tdata[117:116];
            got.action = o_m_axis_tuser;
            if (pending_targets.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got %h", $time, got);
            end else begin
                want = pending_targets.pop_front();
                cmp_field("control_source", want.src, got.src);
                cmp_field("action", want.action, got.action);
                cmp_field("amp_out_joint0", want.amp0, got.amp0);
                cmp_field("amp_out_joint1", want.amp1, got.amp1);
                cmp_field("amp_out_joint2", want.amp2, got.amp2);
                cmp_field("bias_out", want.bias, got.bias);
                cmp_field("frequency_out", want.freq, got.freq);
                cmp_field("replay_request", want.replay, got.replay);
            end
        end
    end

    // result sink: random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && rx_jitter && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_stim_row directed_rows [$];
        t_targets  none;
        none             = '0;
        mismatches       = 0;
        hold_requests    = 0;
        holds_served     = 0;
        rx_jitter        = 1'b0;
        i_rst_n          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        cfg_we           = 1'b0;
        cfg_addr         = rcsto_pkg::CFG_AMP0;
        cfg_wdata        = '0;
        cfg_amp[0]       = rcsto_pkg::AMP0_RST;
        cfg_amp[1]       = rcsto_pkg::AMP1_RST;
        cfg_amp[2]       = rcsto_pkg::AMP2_RST;
        cfg_bias_scale   = rcsto_pkg::BIAS_RST;
        cfg_base_freq    = rcsto_pkg::FREQ_RST;
        cfg_heading_rate = rcsto_pkg::RATE_RST;
        hold_engaged     = 1'b0;
        yaw_goal         = 0;

        // busy frame: nothing changes, source still reported
        directed_rows.push_back('{mk_frame(1500, 1500, 1500, 2000, 2047, 0, 0, 0, 1), 1'b1,
                                  mk_targets(1, rcsto_pkg::ACT_NONE, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_NONE)});
        directed_rows.push_back('{mk_frame(0, 0, 0, 2047, 0, 0, 2047, 0, 0), 1'b1,
                                  mk_targets(0, rcsto_pkg::ACT_ZERO, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_LEFT)});
        directed_rows.push_back('{mk_frame(2047, 2047, 2047, 1751, 1501, 1250, 1249, -1, 0),
                                  1'b1,
                                  mk_targets(1, rcsto_pkg::ACT_ZERO, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_RIGHT)});
        // manual at the zero threshold, sticks at the points that give zero
        directed_rows.push_back('{mk_frame(1500, 2000, 2000, 1750, 1500, 1249, 0, 0, 0), 1'b1,
                                  mk_targets(0, rcsto_pkg::ACT_TARGETS, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_LEFT)});
        // full stick gives the register values themselves
        directed_rows.push_back('{mk_frame(2000, 1000, 1000, 1251, 1000, 2000, 2000, 0, 0), 1'b1,
                                  mk_targets(0, rcsto_pkg::ACT_TARGETS, 11438, 22877, 34315,
                                             34315, 327680, rcsto_pkg::REPLAY_NONE)});
        directed_rows.push_back('{mk_frame(0, 0, 0, 1500, 1501, 2047, 2047, 0, 0), 1'b0, none});
        directed_rows.push_back('{mk_frame(2047, 2047, 2047, 1300, 0, 1500, 1500, 0, 0), 1'b0,
                                  none});
        // heading capture at the threshold
        directed_rows.push_back('{mk_frame(1500, 1500, 1500, 1250, 0, 2000, 2000, 11796480, 0),
                                  1'b1,
                                  mk_targets(0, rcsto_pkg::ACT_CAPTURE, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_NONE)});
        directed_rows.push_back('{mk_frame(1500, 1500, 1500, 1250, 0, 2000, 2000, 11796480, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk_frame(2047, 1000, 2000, 1100, 0, 2000, 2000, -11796480, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk_frame(0, 0, 2047, 0, 2047, 2000, 2000, 0, 0), 1'b0, none});
        directed_rows.push_back('{mk_frame(1500, 1500, 1500, 0, 1501, 0, 2000, 0, 1), 1'b1,
                                  mk_targets(1, rcsto_pkg::ACT_NONE, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_NONE)});
        directed_rows.push_back('{mk_frame(1000, 1200, 1800, 1000, 0, 2000, 2000, -16777216, 0),
                                  1'b0, none});
        directed_rows.push_back('{mk_frame(2000, 1800, 1200, 1000, 0, 2000, 2000, 16777215, 0),
                                  1'b0, none});
        // zero mode drops heading hold, so the next low mode captures again
        directed_rows.push_back('{mk_frame(1500, 1500, 1500, 1800, 0, 2000, 2000, 0, 0), 1'b1,
                                  mk_targets(0, rcsto_pkg::ACT_ZERO, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_NONE)});
        directed_rows.push_back('{mk_frame(1500, 1500, 1500, 0, 0, 2000, 2000, -5000000, 0), 1'b1,
                                  mk_targets(0, rcsto_pkg::ACT_CAPTURE, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_NONE)});
        directed_rows.push_back('{mk_frame(1700, 1500, 1500, 900, 0, 2000, 2000, -4000000, 0),
                                  1'b0, none});
        // manual drops heading hold too
        directed_rows.push_back('{mk_frame(1300, 1600, 1400, 1500, 0, 2000, 2000, 0, 0), 1'b0,
                                  none});
        directed_rows.push_back('{mk_frame(1500, 1500, 1500, 1250, 0, 2000, 1000, 0, 0), 1'b1,
                                  mk_targets(0, rcsto_pkg::ACT_CAPTURE, 0, 0, 0, 0, 0,
                                             rcsto_pkg::REPLAY_RIGHT)});
        directed_rows.push_back('{mk_frame(1600, 1500, 1500, 1250, 0, 0, 0, 123456, 0), 1'b0,
                                  none});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_jitter = 1'b1;

        foreach (directed_rows[i]) begin
            send_frame(directed_rows[i].f, directed_rows[i].known, directed_rows[i].want,
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0);
        end

        // hold off the sink and keep offering until the input stalls
        hold_requests++;
        repeat (30) send_frame(gen_frame(KIND_MANUAL, 1'b0), 1'b0, none, 0);
        wait_drained();

        run_phase(140, 1'b1);
        wait_drained();
        repeat (4) @(posedge i_clk);
        load_settings(SWEEP_RANDOM);
        run_phase(140, 1'b1);
        wait_drained();
        repeat (4) @(posedge i_clk);
        load_settings(SWEEP_ZERO);
        run_phase(120, 1'b1);
        wait_drained();
        repeat (4) @(posedge i_clk);
        load_settings(SWEEP_TOP);
        hold_requests++;
        run_phase(140, 1'b1);
        wait_drained();
        repeat (4) @(posedge i_clk);
        load_settings(SWEEP_ONES);
        run_phase(140, 1'b1);
        wait_drained();
        repeat (4) @(posedge i_clk);
        load_settings(SWEEP_RANDOM);
        rx_jitter = 1'b0;
        run_phase(120, 1'b0);
        wait_drained();

        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/rcsto_pkg.sv
sv/rc_stick_to_oscillator_targets.sv
tb/tb.sv
